@@ sv/pdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants for the proximity dedup counter: the token that
// walks the cell chain, the store write bus and the controller states.
// ----------------------------------------------------------------------------
package pdc_pkg;

   localparam int XY_W   = 16;   // Q3.12 coordinate
   localparam int SQ_W   = 32;   // one squared difference, Q8.24
   localparam int DIST_W = 35;   // threshold width, Q11.24
   localparam int DC_W   = 9;    // distinct_count output width

   localparam logic [DIST_W-1:0] THRESH_RESET = 35'd167772;

   // query point as it moves from cell to cell
   typedef struct packed {
      logic            valid;
      logic [XY_W-1:0] x;
      logic [XY_W-1:0] y;
      logic            last;
      logic            dup;
   } token_type;

   // append a kept point; the target cell is picked by the fill count
   typedef struct packed {
      logic            en;
      logic [XY_W-1:0] x;
      logic [XY_W-1:0] y;
   } wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

endpackage

@@ sv/proximity_dedup_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_dedup_counter
// Greedy distance-threshold deduplication of 2-D point sets, one cell per
// kept point.
// ----------------------------------------------------------------------------
// Each accepted point walks a chain of MAX_POINTS cells (square, then add and
// compare against dup_threshold), and the kept point is appended at the chain
// end; the next point is accepted only after that commit. One point is in
// flight at a time. A finished result sits in the output register while the
// next point is taken. After a point marked last_point the store and the
// count clear. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module proximity_dedup_counter #(
   parameter int MAX_POINTS = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   // configuration
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pdc_pkg::DIST_W-1:0]  csr_dup_threshold,
   // points in
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [pdc_pkg::XY_W-1:0] req_x_coord,
   input  logic signed [pdc_pkg::XY_W-1:0] req_y_coord,
   input  logic                        req_last_point,
   // results out
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_is_new,
   output logic [pdc_pkg::DC_W-1:0]    rsp_distinct_count,
   output logic                        rsp_store_full,
   output logic                        rsp_set_done
);
   import pdc_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

   logic [DIST_W-1:0] thresh_ff, thresh_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   state_type         state_ff, state_in;
   token_type         end_ff, end_in;
   token_type         tok [MAX_POINTS+1];
   wr_type            wr;

   logic              req_xfer;
   logic              commit;
   logic              fresh, store;
   logic [CNT_W-1:0]  cnt_after;
   logic [CNT_W+DC_W-1:0] cnt_ext;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_is_new_ff, rsp_store_full_ff, rsp_set_done_ff;
   logic [DC_W-1:0]   rsp_dc_ff, rsp_dc_in;

   // configuration register
   assign csr_ready = 1'b1;
   assign thresh_in = (csr_valid && csr_ready) ? csr_dup_threshold : thresh_ff;

   // launch the query into the first cell
   assign req_xfer    = req_valid && req_ready;
   assign tok[0].valid = req_xfer;
   assign tok[0].x     = req_x_coord;
   assign tok[0].y     = req_y_coord;
   assign tok[0].last  = req_last_point;
   assign tok[0].dup   = 1'b0;

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      pdc_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_i    (tok[i]),
         .tok_o    (tok[i+1]),
         .wr_i     (wr),
         .count_i  (count_ff),
         .thresh_i (thresh_ff)
      );
   end

   // capture the token leaving the chain
   assign end_in = tok[MAX_POINTS].valid ? tok[MAX_POINTS] : end_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_xfer) state_in = ST_SCAN;
         ST_SCAN:   if (tok[MAX_POINTS].valid) state_in = ST_COMMIT;
         ST_COMMIT: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   ;
         ST_COMMIT: commit = !rsp_valid_ff || rsp_ready;
         default:   ;
      endcase
   end

   // append decision and result
   always_comb begin
      fresh     = !end_ff.dup;
      store     = fresh && (count_ff < CNT_MAX);
      cnt_after = store ? count_ff + CNT_W'(1) : count_ff;
      cnt_ext   = {{DC_W{1'b0}}, cnt_after};
      rsp_dc_in = cnt_ext[DC_W-1:0];
      wr.en     = commit && store;
      wr.x      = end_ff.x;
      wr.y      = end_ff.y;
      count_in  = count_ff;
      if (commit) begin
         count_in = end_ff.last ? '0 : cnt_after;
      end
   end

   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= THRESH_RESET;
         count_ff     <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         thresh_ff    <= thresh_in;
         count_ff     <= count_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff <= end_in;
      if (commit) begin
         rsp_is_new_ff     <= fresh;
         rsp_store_full_ff <= fresh && !store;
         rsp_set_done_ff   <= end_ff.last;
         rsp_dc_ff         <= rsp_dc_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_new         = rsp_is_new_ff;
   assign rsp_distinct_count = rsp_dc_ff;
   assign rsp_store_full     = rsp_store_full_ff;
   assign rsp_set_done       = rsp_set_done_ff;

   // a token leaves the chain only while a scan is running
   a_exit_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok[MAX_POINTS].valid |-> state_ff == ST_SCAN)
      else $error("token left chain outside scan");

   // fill count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("kept count exceeds store depth");

   // the end of a set clears the store
   a_set_clear: assert property (@(posedge clock) disable iff (reset)
      (commit && end_ff.last) |=> count_ff == '0)
      else $error("count not cleared after last point");

   // a result appears only from a commit
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COMMIT))
      else $error("result without commit");

endmodule

@@ sv/pdc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_cell
// One store slot. Holds a kept point, squares the distance to the passing
// query in a first stage, then adds, compares and hands the token on.
// ----------------------------------------------------------------------------
module pdc_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 9
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pdc_pkg::token_type          tok_i,
   output pdc_pkg::token_type          tok_o,
   input  pdc_pkg::wr_type             wr_i,
   input  logic [CNT_W-1:0]            count_i,
   input  logic [pdc_pkg::DIST_W-1:0]  thresh_i
);
   import pdc_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic [XY_W-1:0]        pt_x_ff, pt_y_ff;
   logic signed [XY_W:0]   dx, dy;
   logic signed [2*XY_W+1:0] px, py;
   logic [SQ_W-1:0]        sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   logic                   occ_ff, occ_in;
   token_type              mid_ff, mid_in;
   token_type              out_ff, out_in;
   logic [SQ_W:0]          sum;
   logic                   hit;

   // stage 1: differences and squares
   always_comb begin
      dx      = $signed({tok_i.x[XY_W-1], tok_i.x}) - $signed({pt_x_ff[XY_W-1], pt_x_ff});
      dy      = $signed({tok_i.y[XY_W-1], tok_i.y}) - $signed({pt_y_ff[XY_W-1], pt_y_ff});
      px      = dx * dx;
      py      = dy * dy;
      sq_x_in = px[SQ_W-1:0];
      sq_y_in = py[SQ_W-1:0];
      occ_in  = MY_IDX < count_i;
      mid_in  = tok_i;
   end

   // stage 2: sum, compare, fold into the duplicate flag
   always_comb begin
      sum        = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
      hit        = occ_ff && ({{(DIST_W-SQ_W-1){1'b0}}, sum} < thresh_i);
      out_in     = mid_ff;
      out_in.dup = mid_ff.dup | hit;
   end

   always_ff @(posedge clock) begin
      if (wr_i.en && (count_i == MY_IDX)) begin
         pt_x_ff <= wr_i.x;
         pt_y_ff <= wr_i.y;
      end
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      occ_ff  <= occ_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= '0;
         out_ff <= '0;
      end else begin
         mid_ff <= mid_in;
         out_ff <= out_in;
      end
   end

   assign tok_o = out_ff;

endmodule

@@ tb/pdc_dedup_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_dedup_check
// Watches the threshold, point and result channels of the proximity dedup
// counter, keeps its own copy of the kept-point store and the distinct count,
// works out the answer for every point transfer and compares each result
// transfer against the oldest answer still due.
// ----------------------------------------------------------------------------
module pdc_dedup_check #(
   parameter int MAX_POINTS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [pdc_pkg::DIST_W-1:0]      csr_dup_threshold,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic signed [pdc_pkg::XY_W-1:0] req_x_coord,
   input  logic signed [pdc_pkg::XY_W-1:0] req_y_coord,
   input  logic                            req_last_point,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_is_new,
   input  logic [pdc_pkg::DC_W-1:0]        rsp_distinct_count,
   input  logic                            rsp_store_full,
   input  logic                            rsp_set_done,
   output int                              mismatch_count,
   output int                              answers_due
);
   import pdc_pkg::*;

   typedef struct packed {
      logic            is_new;
      logic [DC_W-1:0] count;
      logic            full;
      logic            done;
   } dedup_answer_type;

   logic [DIST_W-1:0] threshold;
   logic [2*XY_W-1:0] kept_xy [MAX_POINTS];
   int                kept_count;
   dedup_answer_type  pending_answers [$];

   function automatic string answer_text(input dedup_answer_type a);
      return $sformatf("is_new=%0b count=%0d full=%0b done=%0b",
                       a.is_new, a.count, a.full, a.done);
   endfunction

   // Greedy dedup of one point against every point kept so far in this set.
   function automatic dedup_answer_type admit_point(input logic signed [XY_W-1:0] px,
                                                    input logic signed [XY_W-1:0] py,
                                                    input logic last);
      dedup_answer_type     ans;
      logic signed [XY_W:0] dx;
      logic signed [XY_W:0] dy;
      logic [SQ_W-1:0]      sqx;
      logic [SQ_W-1:0]      sqy;
      logic [DIST_W-1:0]    sq_sum;
      logic                 fresh;
      int                   i;
      fresh = 1'b1;
      for (i = 0; i < kept_count && fresh; i++) begin
         dx     = $signed(kept_xy[i][2*XY_W-1:XY_W]) - px;
         dy     = $signed(kept_xy[i][XY_W-1:0]) - py;
         sqx    = dx * dx;
         sqy    = dy * dy;
         sq_sum = {{(DIST_W-SQ_W){1'b0}}, sqx} + {{(DIST_W-SQ_W){1'b0}}, sqy};
         if (sq_sum < threshold)
            fresh = 1'b0;
      end
      ans.full = 1'b0;
      if (fresh) begin
         if (kept_count < MAX_POINTS) begin
            kept_xy[kept_count] = {px, py};
            kept_count++;
         end else begin
            // store full: flag it, drop it, hold the count
            ans.full = 1'b1;
         end
      end
      ans.is_new = fresh;
      ans.count  = kept_count[DC_W-1:0];
      ans.done   = last;
      if (last)
         kept_count = 0;
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      dedup_answer_type want;
      dedup_answer_type got;
      if (reset) begin
         threshold      = THRESH_RESET;
         kept_count     = 0;
         mismatch_count = 0;
         pending_answers.delete();
      end else begin
         if (csr_valid && csr_ready)
            threshold = csr_dup_threshold;
         if (req_valid && req_ready)
            pending_answers.push_back(admit_point(req_x_coord, req_y_coord,
                                                  req_last_point));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_is_new, rsp_distinct_count, rsp_store_full, rsp_set_done};
            if (pending_answers.size() == 0) begin
               mismatch_count++;
               $display("%0t: result transfer with none due: expected none, actual %s",
                        $time, answer_text(got));
            end else begin
               want = pending_answers.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  $display("%0t: result mismatch: expected %s, actual %s",
                           $time, answer_text(want), answer_text(got));
               end
            end
         end
      end
      answers_due = pending_answers.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Point-set stimulus for the proximity dedup counter: a directed pass over
// the threshold edge, the coordinate extremes and one-point sets, a set that
// overflows the kept-point store, then random sets at several thresholds,
// with random idling on both channels and a verdict at the end.
// ----------------------------------------------------------------------------
module tb;
   import pdc_pkg::*;

   localparam int MAX_POINTS      = 256;
   localparam int POINT_CYCLES    = 2 * MAX_POINTS + 2;
   localparam int STALL_LIMIT     = 8 * POINT_CYCLES;
   localparam int PHASE_ITEMS     = 190;
   localparam int PHASE_COUNT     = 7;
   localparam int FULL_SET_POINTS = MAX_POINTS + 4;
   localparam logic [DIST_W-1:0] THRESH_MAX = '1;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [DIST_W-1:0]       csr_dup_threshold = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [XY_W-1:0]  req_x_coord = '0;
   logic signed [XY_W-1:0]  req_y_coord = '0;
   logic                    req_last_point = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_is_new;
   logic [DC_W-1:0]         rsp_distinct_count;
   logic                    rsp_store_full;
   logic                    rsp_set_done;

   int   mismatch_count;
   int   answers_due;
   logic no_idle = 1'b0;
   int   ready_left = 0;
   int   quiet_cycles = 0;

   proximity_dedup_counter #(
      .MAX_POINTS(MAX_POINTS)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_dup_threshold  (csr_dup_threshold),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_x_coord        (req_x_coord),
      .req_y_coord        (req_y_coord),
      .req_last_point     (req_last_point),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_new         (rsp_is_new),
      .rsp_distinct_count (rsp_distinct_count),
      .rsp_store_full     (rsp_store_full),
      .rsp_set_done       (rsp_set_done)
   );

   pdc_dedup_check #(
      .MAX_POINTS(MAX_POINTS)
   ) u_dedup_check (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_dup_threshold  (csr_dup_threshold),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_x_coord        (req_x_coord),
      .req_y_coord        (req_y_coord),
      .req_last_point     (req_last_point),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_new         (rsp_is_new),
      .rsp_distinct_count (rsp_distinct_count),
      .rsp_store_full     (rsp_store_full),
      .rsp_set_done       (rsp_set_done),
      .mismatch_count     (mismatch_count),
      .answers_due        (answers_due)
   );

   always #4 clock = ~clock;

   // result side: alternate ready runs and stall bursts
   always @(negedge clock) begin
      if (no_idle) begin
         rsp_ready <= 1'b1;
      end else if (ready_left == 0) begin
         if ($urandom_range(0, 2) == 0) begin
            rsp_ready  <= 1'b0;
            ready_left = $urandom_range(1, 10);
         end else begin
            rsp_ready  <= 1'b1;
            ready_left = $urandom_range(1, 30);
         end
      end else begin
         ready_left--;
      end
   end

   // end the run if no channel moves a transfer for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("** proximity_dedup_counter: FAILED **");
         $finish;
      end
   end

   function automatic logic signed [XY_W-1:0] clamp_coord(input int v);
      if (v > 32767)
         return 16'sh7FFF;
      if (v < -32768)
         return 16'sh8000;
      return v[XY_W-1:0];
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_point(input logic signed [XY_W-1:0] px,
                             input logic signed [XY_W-1:0] py,
                             input logic last);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_x_coord    <= px;
      req_y_coord    <= py;
      req_last_point <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_threshold(input logic [DIST_W-1:0] value);
      req_valid <= 1'b0;
      while (answers_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid         <= 1'b1;
      csr_dup_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One set: fresh random points, exact repeats and near neighbors.
   task automatic send_set(input int n);
      logic signed [XY_W-1:0] xs [64];
      logic signed [XY_W-1:0] ys [64];
      logic signed [XY_W-1:0] px;
      logic signed [XY_W-1:0] py;
      int k;
      int pick;
      int idx;
      int span;
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(0, 9);
         if (k == 0 || pick < 3) begin
            px = XY_W'($urandom);
            py = XY_W'($urandom);
         end else begin
            idx = $urandom_range(0, k - 1);
            px  = xs[idx];
            py  = ys[idx];
            if (pick >= 5) begin
               case ($urandom_range(0, 2))
                  0:       span = 16;
                  1:       span = 600;
                  default: span = 4000;
               endcase
               px = clamp_coord(int'(px) + int'($urandom_range(0, 2 * span)) - span);
               py = clamp_coord(int'(py) + int'($urandom_range(0, 2 * span)) - span);
            end
         end
         xs[k] = px;
         ys[k] = py;
         send_point(px, py, k == n - 1);
      end
   endtask

   initial begin : stimulus
      logic [DIST_W-1:0] thr;
      int phase;
      int sent;
      int n;
      int k;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset threshold: 409 units apart is a duplicate, 410 is not
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sd100, -16'sd100, 1'b0);
      send_point(16'sd409, 16'sd0, 1'b0);
      send_point(16'sd410, 16'sd0, 1'b0);
      send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
      send_point(16'sh8000, 16'sh8000, 1'b0);
      send_point(16'sh8000, 16'sh7FFF, 1'b0);
      send_point(16'sh7FFF, 16'sh8000, 1'b1);
      // one-point set, then a set closed by a duplicate
      send_point(16'sd0, 16'sd0, 1'b1);
      send_point(16'sd5, 16'sd5, 1'b0);
      send_point(16'sd5, 16'sd5, 1'b1);

      // distance equal to the threshold counts as new
      write_threshold(35'd168100);
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sd410, 16'sd0, 1'b0);
      send_point(16'sd0, 16'sd409, 1'b1);

      // largest threshold: everything after the first point is a duplicate
      write_threshold(THRESH_MAX);
      send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
      send_point(16'sh8000, 16'sh8000, 1'b0);
      send_point(16'sd0, 16'sd0, 1'b1);

      // zero threshold: every point is new, so the store overflows
      write_threshold('0);
      for (k = 0; k < FULL_SET_POINTS; k++)
         send_point(XY_W'($urandom), XY_W'($urandom), k == FULL_SET_POINTS - 1);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       thr = THRESH_RESET;
            1:       thr = 35'd1;
            2:       thr = DIST_W'($urandom_range(1, 1 << 24));
            3:       thr = DIST_W'({$urandom, $urandom});
            4:       thr = THRESH_MAX;
            5:       thr = DIST_W'($urandom_range(1 << 20, 1 << 26));
            default: thr = THRESH_RESET;
         endcase
         if (phase == PHASE_COUNT - 1)
            no_idle <= 1'b1;
         write_threshold(thr);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if (n > PHASE_ITEMS - sent)
               n = PHASE_ITEMS - sent;
            send_set(n);
            sent += n;
         end
      end

      // drain, then give a stray result time to show up
      req_valid <= 1'b0;
      while (answers_due != 0) @(negedge clock);
      repeat (POINT_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("** proximity_dedup_counter: PASSED **");
      else
         $display("** proximity_dedup_counter: FAILED **");
      $finish;
   end

endmodule

@@ proximity_dedup_counter.f @@
sv/pdc_pkg.sv
sv/pdc_cell.sv
sv/proximity_dedup_counter.sv
tb/pdc_dedup_check.sv
tb/tb.sv
